FILE: rtl/oah_pkg.sv
// Package for the open-addressing hash insert engine.
// Field widths, operation and status codes, config register indexes, word types.
// No dependencies.
`default_nettype none

package oah_pkg;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 31;
  localparam int SLOT_W   = 6;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 8;
  localparam int SUM_W    = 14;
  localparam int PMODE_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [SUM_W-1:0] SUM_MAX        = '1;
  localparam logic [CNT_W-1:0] MAX_PROBES_RST = 8'd50;

  localparam logic [MODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [MODE_W-1:0] OP_READ   = 2'd2;

  localparam logic [PMODE_W-1:0] PM_LINEAR = 2'd0;
  localparam logic [PMODE_W-1:0] PM_QUAD   = 2'd1;
  localparam logic [PMODE_W-1:0] PM_DOUBLE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_GAVE_UP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_READ     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PROBES = 1'd1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   where;
    logic [KEY_W-1:0]    stored_key;
    logic                slot_used;
    logic [CNT_W-1:0]    probes;
    logic [SUM_W-1:0]    total_probes;
  } out_word_t;

endpackage

`default_nettype wire

FILE: rtl/oah_stream_if.sv
// Valid/ready stream channel carrying one word per handshake.
// Word type is a parameter, normally oah_pkg::in_word_t or oah_pkg::out_word_t.
`default_nettype none

interface oah_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/open_addressing_hash_insert_top.sv
// Open-addressing hash table engine: insert, clear, read slot.
// Depends on oah_pkg and oah_stream_if.
//
// One operation is in flight at a time; a new word is taken whenever the engine is idle, even
// while the previous result waits on the output register. Insert: the word is accepted, the key
// is reduced mod TABLE_SIZE (4 key bits per cycle), then slots are probed in turn on the single
// read port of the slot memory until one is free or the collision count reaches max_probes.
// Double hashing first reduces home mod DH_MODULUS and then the step mod TABLE_SIZE. Clear
// sweeps the memory. After reset the engine runs a clearing pass before it accepts a word;
// config writes are taken always.
`default_nettype none

module open_addressing_hash_insert_top #(
  parameter int TABLE_SIZE = 64,
  parameter int DH_OFFSET  = 30,
  parameter int DH_MODULUS = 25
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [oah_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [oah_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  oah_stream_if.sink                           in_i,
  oah_stream_if.source                         out_o
);

  localparam int IW      = $clog2(TABLE_SIZE);
  localparam int MAXD    = (TABLE_SIZE > DH_MODULUS) ? TABLE_SIZE : DH_MODULUS;
  localparam int RW      = $clog2(MAXD) + 1;
  localparam int DH_K    = (DH_MODULUS + TABLE_SIZE - 1) / TABLE_SIZE;
  localparam int BIAS    = DH_OFFSET + DH_K * TABLE_SIZE;
  localparam int VW      = $clog2(BIAS + 1);
  localparam int ND_KEY  = 8;
  localparam int ND_HOME = (IW + 3) / 4;
  localparam int ND_V    = (VW + 3) / 4;
  localparam int HOME_SH = 32 - 4 * ND_HOME;
  localparam int V_SH    = 32 - 4 * ND_V;

  localparam logic [IW:0]   T_EXT     = (IW + 1)'(TABLE_SIZE);
  localparam logic [IW-1:0] TWO_MOD_T = IW'(2 % TABLE_SIZE);
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);

  typedef struct packed {
    logic                            valid;
    logic [oah_pkg::CNT_W-1:0]       cnt;
    logic [oah_pkg::KEY_W-1:0]       key;
  } entry_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HASH, S_DHM, S_DHT, S_PCHK, S_CLR, S_CLRD, S_SCHK
  } state_e;

  function automatic logic [RW-1:0] red_digit(input logic [RW-1:0] acc,
                                              input logic [3:0]    dig,
                                              input logic [RW-1:0] div);
    logic [RW-1:0] t;
    t = acc;
    for (int b = 3; b >= 0; b--) begin
      t = {t[RW-2:0], dig[b]};
      if (t >= div) t = t - div;
    end
    return t;
  endfunction

  function automatic logic [IW-1:0] mod_add(input logic [IW-1:0] a, input logic [IW-1:0] b);
    logic [IW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= T_EXT) s = s - T_EXT;
    return s[IW-1:0];
  endfunction

  // slot memory
  entry_t          mem [TABLE_SIZE];
  entry_t          rdata_q;
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr, mem_raddr;
  entry_t          mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  state_e                          state_q, state_d;
  logic [oah_pkg::PMODE_W-1:0]     pmode_q, pmode_d;
  logic [oah_pkg::CNT_W-1:0]       maxp_q, maxp_d;
  logic [oah_pkg::KEY_W-1:0]       key_q, key_d;
  logic [oah_pkg::SLOT_W-1:0]      slot_q, slot_d;
  logic                            slot_ok_q, slot_ok_d;
  logic [RW-1:0]                   acc_q, acc_d;
  logic [31:0]                     src_q, src_d;
  logic [2:0]                      dig_q, dig_d;
  logic [IW-1:0]                   pos_q, pos_d;
  logic [IW-1:0]                   inc_q, inc_d;
  logic [oah_pkg::CNT_W-1:0]       i_q, i_d;
  logic [oah_pkg::SUM_W-1:0]       sum_q, sum_d;
  oah_pkg::out_word_t              out_q, out_d;
  logic                            out_valid_q, out_valid_d;

  logic                            in_fire, out_free, emit, slot_in_range;
  logic [RW-1:0]                   div, acc_step;
  logic [IW-1:0]                   pos_nx;
  logic [VW-1:0]                   dh_v;
  logic [oah_pkg::SUM_W:0]         sum_ext;
  logic [oah_pkg::SUM_W-1:0]       sum_sat;

  assign in_i.ready    = (state_q == S_IDLE);
  assign in_fire       = in_i.valid && in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
  assign out_free      = !out_valid_q || out_o.ready;

  assign slot_in_range = (32'(in_i.payload.slot) < 32'(TABLE_SIZE));
  assign div      = (state_q == S_DHM) ? RW'(DH_MODULUS) : RW'(TABLE_SIZE);
  assign acc_step = red_digit(acc_q, src_q[31:28], div);
  assign pos_nx   = mod_add(pos_q, inc_q);
  assign dh_v     = VW'(BIAS) - VW'(acc_step);
  assign sum_ext  = {1'b0, sum_q} + (oah_pkg::SUM_W + 1)'(i_q);
  assign sum_sat  = sum_ext[oah_pkg::SUM_W] ? oah_pkg::SUM_MAX : sum_ext[oah_pkg::SUM_W-1:0];

  always_comb begin
    state_d   = state_q;
    pmode_d   = pmode_q;
    maxp_d    = maxp_q;
    key_d     = key_q;
    slot_d    = slot_q;
    slot_ok_d = slot_ok_q;
    acc_d     = acc_q;
    src_d     = src_q;
    dig_d     = dig_q;
    pos_d     = pos_q;
    inc_d     = inc_q;
    i_d       = i_q;
    sum_d     = sum_q;
    out_d     = out_q;
    emit      = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = pos_q;
    mem_raddr = pos_q;
    mem_wdata = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        oah_pkg::CFG_PROBE_MODE: pmode_d = cfg_data_i[oah_pkg::PMODE_W-1:0];
        oah_pkg::CFG_MAX_PROBES: maxp_d  = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_INIT, S_CLR: begin
        mem_we = 1'b1;
        if (pos_q == LAST_SLOT) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_CLRD;
        end else begin
          pos_d = pos_q + IW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          key_d  = in_i.payload.key;
          slot_d = in_i.payload.slot;
          case (in_i.payload.mode)
            oah_pkg::OP_INSERT: begin
              src_d   = {1'b0, in_i.payload.key};
              acc_d   = '0;
              dig_d   = 3'(ND_KEY - 1);
              state_d = S_HASH;
            end
            oah_pkg::OP_CLEAR: begin
              pos_d   = '0;
              state_d = S_CLR;
            end
            default: begin
              slot_ok_d = slot_in_range;
              mem_re    = slot_in_range;
              mem_raddr = IW'(in_i.payload.slot);
              state_d   = S_SCHK;
            end
          endcase
        end
      end
      S_HASH: begin
        acc_d = acc_step;
        src_d = src_q << 4;
        dig_d = dig_q - 3'd1;
        if (dig_q == 3'd0) begin
          pos_d = IW'(acc_step);
          i_d   = '0;
          if (pmode_q == oah_pkg::PM_DOUBLE) begin
            acc_d   = '0;
            src_d   = 32'(IW'(acc_step)) << HOME_SH;
            dig_d   = 3'(ND_HOME - 1);
            state_d = S_DHM;
          end else begin
            inc_d     = IW'(1);
            mem_re    = 1'b1;
            mem_raddr = IW'(acc_step);
            state_d   = S_PCHK;
          end
        end
      end
      S_DHM: begin
        acc_d = acc_step;
        src_d = src_q << 4;
        dig_d = dig_q - 3'd1;
        if (dig_q == 3'd0) begin
          acc_d   = '0;
          src_d   = 32'(dh_v) << V_SH;
          dig_d   = 3'(ND_V - 1);
          state_d = S_DHT;
        end
      end
      S_DHT: begin
        acc_d = acc_step;
        src_d = src_q << 4;
        dig_d = dig_q - 3'd1;
        if (dig_q == 3'd0) begin
          inc_d   = IW'(acc_step);
          mem_re  = 1'b1;
          state_d = S_PCHK;
        end
      end
      S_PCHK: begin
        if (!rdata_q.valid) begin
          if (out_free) begin
            mem_we             = 1'b1;
            mem_wdata          = '{valid: 1'b1, cnt: i_q, key: key_q};
            sum_d              = sum_sat;
            emit               = 1'b1;
            out_d              = '0;
            out_d.status       = oah_pkg::ST_INSERTED;
            out_d.where        = oah_pkg::SLOT_W'(pos_q);
            out_d.probes       = i_q;
            out_d.total_probes = sum_sat;
            state_d            = S_IDLE;
          end
        end else if (i_q == maxp_q) begin
          if (out_free) begin
            emit               = 1'b1;
            out_d              = '0;
            out_d.status       = oah_pkg::ST_GAVE_UP;
            out_d.probes       = maxp_q;
            out_d.total_probes = sum_q;
            state_d            = S_IDLE;
          end
        end else begin
          i_d       = i_q + 8'd1;
          pos_d     = pos_nx;
          if (pmode_q == oah_pkg::PM_QUAD) inc_d = mod_add(inc_q, TWO_MOD_T);
          mem_re    = 1'b1;
          mem_raddr = pos_nx;
        end
      end
      S_CLRD: begin
        if (out_free) begin
          sum_d        = '0;
          emit         = 1'b1;
          out_d        = '0;
          out_d.status = oah_pkg::ST_CLEARED;
          state_d      = S_IDLE;
        end
      end
      S_SCHK: begin
        if (out_free) begin
          emit               = 1'b1;
          out_d              = '0;
          out_d.status       = oah_pkg::ST_READ;
          out_d.where        = slot_q;
          out_d.total_probes = sum_q;
          if (slot_ok_q && rdata_q.valid) begin
            out_d.slot_used  = 1'b1;
            out_d.stored_key = rdata_q.key;
            out_d.probes     = rdata_q.cnt;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      pmode_q     <= oah_pkg::PM_LINEAR;
      maxp_q      <= oah_pkg::MAX_PROBES_RST;
      key_q       <= '0;
      slot_q      <= '0;
      slot_ok_q   <= 1'b0;
      acc_q       <= '0;
      src_q       <= '0;
      dig_q       <= '0;
      pos_q       <= '0;
      inc_q       <= '0;
      i_q         <= '0;
      sum_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pmode_q     <= pmode_d;
      maxp_q      <= maxp_d;
      key_q       <= key_d;
      slot_q      <= slot_d;
      slot_ok_q   <= slot_ok_d;
      acc_q       <= acc_d;
      src_q       <= src_d;
      dig_q       <= dig_d;
      pos_q       <= pos_d;
      inc_q       <= inc_d;
      i_q         <= i_d;
      sum_q       <= sum_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a result is only produced when the output register can take it
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_o.ready))
    else $error("result produced while output register is held");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("engine still idle after accepting a word");

  a_probe_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PCHK) |-> ((32'(pos_q) < 32'(TABLE_SIZE)) && (32'(inc_q) < 32'(TABLE_SIZE))))
    else $error("probe position or step outside the table");

  a_probe_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PCHK) |-> (i_q <= maxp_q))
    else $error("collision count passed max_probes");

endmodule

`default_nettype wire

FILE: tb/tb_open_addressing_hash_insert_top.sv
// Testbench for open_addressing_hash_insert_top: directed rows, then random phases with
// reconfiguration, checked against an in-bench hash table predictor.
// Depends on oah_pkg, oah_stream_if and the top level.
module tb_open_addressing_hash_insert_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_SIZE      = 64;
  localparam int DH_OFF        = 30;
  localparam int DH_MOD        = 25;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_ITEMS   = 70;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 40;
  localparam int QUIET_LIMIT   = 4000;

  localparam logic [oah_pkg::MODE_W-1:0]  OP_READ_ALT   = 2'd3;
  localparam logic [oah_pkg::PMODE_W-1:0] PM_LINEAR_ALT = 2'd3;

  typedef enum logic [1:0] {ROW_PREDICTED, ROW_TYPED, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e                          kind;
    oah_pkg::in_word_t                  word;
    oah_pkg::out_word_t                 want;
    logic [oah_pkg::CFG_IDX_W-1:0]      idx;
    logic [oah_pkg::CFG_DATA_W-1:0]     data;
  } dir_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [oah_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [oah_pkg::CFG_DATA_W-1:0] cfg_data_i;

  oah_stream_if #(.word_t(oah_pkg::in_word_t))  in_if ();
  oah_stream_if #(.word_t(oah_pkg::out_word_t)) out_if ();

  open_addressing_hash_insert_top #(
    .TABLE_SIZE(TBL_SIZE),
    .DH_OFFSET (DH_OFF),
    .DH_MODULUS(DH_MOD)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // predictor state
  bit                          slot_full [TBL_SIZE];
  logic [oah_pkg::KEY_W-1:0]   slot_key  [TBL_SIZE];
  logic [oah_pkg::CNT_W-1:0]   slot_cnt  [TBL_SIZE];
  int                          probe_total;
  logic [oah_pkg::PMODE_W-1:0] probe_mode;
  logic [oah_pkg::CNT_W-1:0]   max_probes;

  oah_pkg::out_word_t pending_results[$];
  dir_row_t           dir_rows[$];
  int                 mismatches;
  int                 burst_left;

  function automatic oah_pkg::out_word_t hash_table_op(input oah_pkg::in_word_t w);
    oah_pkg::out_word_t r;
    int        home;
    int        stride;
    int        pos;
    int        i;
    bit        placed;
    r = '0;
    case (w.mode)
      oah_pkg::OP_INSERT: begin
        home = int'(w.key % TBL_SIZE);
        stride = (DH_OFF - home % DH_MOD) % TBL_SIZE;
        if (stride < 0) stride += TBL_SIZE;
        r.status = oah_pkg::ST_GAVE_UP;
        r.probes = max_probes;
        placed = 1'b0;
        i = 0;
        while (!placed && i <= int'(max_probes)) begin
          case (probe_mode)
            oah_pkg::PM_QUAD:   pos = (home + i * i) % TBL_SIZE;
            oah_pkg::PM_DOUBLE: pos = (home + i * stride) % TBL_SIZE;
            default:            pos = (home + i) % TBL_SIZE;
          endcase
          if (!slot_full[pos]) begin
            slot_full[pos] = 1'b1;
            slot_key[pos] = w.key;
            slot_cnt[pos] = oah_pkg::CNT_W'(i);
            probe_total = probe_total + i;
            if (probe_total > int'(oah_pkg::SUM_MAX)) probe_total = int'(oah_pkg::SUM_MAX);
            r.status = oah_pkg::ST_INSERTED;
            r.where = oah_pkg::SLOT_W'(pos);
            r.probes = oah_pkg::CNT_W'(i);
            placed = 1'b1;
          end
          i++;
        end
      end
      oah_pkg::OP_CLEAR: begin
        foreach (slot_full[n]) slot_full[n] = 1'b0;
        probe_total = 0;
        r.status = oah_pkg::ST_CLEARED;
      end
      default: begin
        r.status = oah_pkg::ST_READ;
        r.where = w.slot;
        if (int'(w.slot) < TBL_SIZE && slot_full[w.slot]) begin
          r.slot_used = 1'b1;
          r.stored_key = slot_key[w.slot];
          r.probes = slot_cnt[w.slot];
        end
      end
    endcase
    r.total_probes = oah_pkg::SUM_W'(probe_total);
    return r;
  endfunction

  function automatic dir_row_t op_row(input logic [oah_pkg::MODE_W-1:0] mode,
                                      input logic [oah_pkg::KEY_W-1:0] key, input int slot);
    dir_row_t row;
    row = '0;
    row.kind = ROW_PREDICTED;
    row.word.mode = mode;
    row.word.key = key;
    row.word.slot = oah_pkg::SLOT_W'(slot);
    return row;
  endfunction

  function automatic dir_row_t chk_row(input logic [oah_pkg::MODE_W-1:0] mode,
                                       input logic [oah_pkg::KEY_W-1:0] key, input int slot,
                                       input logic [oah_pkg::STATUS_W-1:0] status,
                                       input int where,
                                       input logic [oah_pkg::KEY_W-1:0] skey, input bit used,
                                       input int probes, input int sum);
    dir_row_t row;
    row = op_row(mode, key, slot);
    row.kind = ROW_TYPED;
    row.want.status = status;
    row.want.where = oah_pkg::SLOT_W'(where);
    row.want.stored_key = skey;
    row.want.slot_used = used;
    row.want.probes = oah_pkg::CNT_W'(probes);
    row.want.total_probes = oah_pkg::SUM_W'(sum);
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [oah_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [oah_pkg::CFG_DATA_W-1:0] data);
    dir_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  // keys mostly clustered on a few home slots to force collisions
  function automatic logic [oah_pkg::KEY_W-1:0] pick_key();
    logic [oah_pkg::KEY_W-1:0] k;
    int                        sel;
    sel = $urandom_range(0, 9);
    k = oah_pkg::KEY_W'($urandom);
    if (sel == 0) k = '0;
    else if (sel == 1) k = '1;
    else if (sel >= 6) k[oah_pkg::SLOT_W-1:0] = oah_pkg::SLOT_W'($urandom_range(0, 7));
    return k;
  endfunction

  function automatic oah_pkg::in_word_t pick_word(input bit allow_clear);
    oah_pkg::in_word_t w;
    int                sel;
    w.key = pick_key();
    w.slot = oah_pkg::SLOT_W'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 60) w.mode = oah_pkg::OP_INSERT;
    else if (sel < 86) w.mode = oah_pkg::OP_READ;
    else if (sel < 93) w.mode = OP_READ_ALT;
    else w.mode = allow_clear ? oah_pkg::OP_CLEAR : oah_pkg::OP_READ;
    return w;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_word(input oah_pkg::in_word_t w, input bit typed,
                           input oah_pkg::out_word_t want);
    int                 gap;
    oah_pkg::out_word_t got;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
    got = hash_table_op(w);
    pending_results.push_back(typed ? want : got);
  endtask

  // registers change only with the engine idle
  task automatic write_reg(input logic [oah_pkg::CFG_IDX_W-1:0] idx,
                           input logic [oah_pkg::CFG_DATA_W-1:0] data);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == oah_pkg::CFG_PROBE_MODE) probe_mode = data[oah_pkg::PMODE_W-1:0];
    else max_probes = data;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : receiver
    int seg_left;
    int style;
    out_if.ready = 1'b0;
    seg_left = 0;
    style = 0;
    forever begin
      @(posedge clk_i);
      if (seg_left == 0) begin
        style = $urandom_range(0, 2);
        seg_left = $urandom_range(16, 160);
      end
      seg_left--;
      case (style)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        default: out_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    oah_pkg::out_word_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %p", $time, out_if.payload);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_if.payload.status));
        check_field("where", 32'(want.where), 32'(out_if.payload.where));
        check_field("stored_key", 32'(want.stored_key), 32'(out_if.payload.stored_key));
        check_field("slot_used", 32'(want.slot_used), 32'(out_if.payload.slot_used));
        check_field("probes", 32'(want.probes), 32'(out_if.payload.probes));
        check_field("total_probes", 32'(want.total_probes),
                    32'(out_if.payload.total_probes));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("open_addressing_hash_insert_top verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [oah_pkg::CFG_DATA_W-1:0] reg_data;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    foreach (slot_full[n]) begin
      slot_full[n] = 1'b0;
      slot_key[n] = '0;
      slot_cnt[n] = '0;
    end
    probe_total = 0;
    probe_mode = oah_pkg::PM_LINEAR;
    max_probes = oah_pkg::MAX_PROBES_RST;
    mismatches = 0;
    burst_left = 0;

    dir_rows.push_back(chk_row(oah_pkg::OP_READ, 31'd0, 0,
                               oah_pkg::ST_READ, 0, 31'd0, 1'b0, 0, 0));
    dir_rows.push_back(chk_row(oah_pkg::OP_INSERT, 31'd0, 0,
                               oah_pkg::ST_INSERTED, 0, 31'd0, 1'b0, 0, 0));
    dir_rows.push_back(chk_row(oah_pkg::OP_INSERT, 31'd64, 0,
                               oah_pkg::ST_INSERTED, 1, 31'd0, 1'b0, 1, 1));
    dir_rows.push_back(chk_row(oah_pkg::OP_INSERT, 31'h7FFFFFFF, 63,
                               oah_pkg::ST_INSERTED, 63, 31'd0, 1'b0, 0, 1));
    // wraps past the top of the table
    dir_rows.push_back(chk_row(oah_pkg::OP_INSERT, 31'd127, 0,
                               oah_pkg::ST_INSERTED, 2, 31'd0, 1'b0, 3, 4));
    dir_rows.push_back(chk_row(oah_pkg::OP_READ, 31'd0, 63,
                               oah_pkg::ST_READ, 63, 31'h7FFFFFFF, 1'b1, 0, 4));
    dir_rows.push_back(chk_row(oah_pkg::OP_READ, 31'd0, 2,
                               oah_pkg::ST_READ, 2, 31'd127, 1'b1, 3, 4));
    dir_rows.push_back(chk_row(OP_READ_ALT, 31'd0, 1,
                               oah_pkg::ST_READ, 1, 31'd64, 1'b1, 1, 4));
    dir_rows.push_back(cfg_row(oah_pkg::CFG_MAX_PROBES, 8'd0));
    dir_rows.push_back(chk_row(oah_pkg::OP_INSERT, 31'd128, 0,
                               oah_pkg::ST_GAVE_UP, 0, 31'd0, 1'b0, 0, 4));
    dir_rows.push_back(chk_row(oah_pkg::OP_INSERT, 31'd5, 0,
                               oah_pkg::ST_INSERTED, 5, 31'd0, 1'b0, 0, 4));
    dir_rows.push_back(cfg_row(oah_pkg::CFG_MAX_PROBES, 8'd255));
    dir_rows.push_back(cfg_row(oah_pkg::CFG_PROBE_MODE,
                               oah_pkg::CFG_DATA_W'(oah_pkg::PM_QUAD)));
    // duplicate key is stored again
    dir_rows.push_back(chk_row(oah_pkg::OP_INSERT, 31'd0, 0,
                               oah_pkg::ST_INSERTED, 4, 31'd0, 1'b0, 2, 6));
    dir_rows.push_back(op_row(oah_pkg::OP_INSERT, 31'h7FFFFFFF, 0));
    dir_rows.push_back(chk_row(oah_pkg::OP_CLEAR, 31'd0, 0,
                               oah_pkg::ST_CLEARED, 0, 31'd0, 1'b0, 0, 0));
    dir_rows.push_back(cfg_row(oah_pkg::CFG_PROBE_MODE,
                               oah_pkg::CFG_DATA_W'(oah_pkg::PM_DOUBLE)));
    dir_rows.push_back(chk_row(oah_pkg::OP_INSERT, 31'd10, 0,
                               oah_pkg::ST_INSERTED, 10, 31'd0, 1'b0, 0, 0));
    dir_rows.push_back(chk_row(oah_pkg::OP_INSERT, 31'd74, 0,
                               oah_pkg::ST_INSERTED, 30, 31'd0, 1'b0, 1, 1));
    dir_rows.push_back(chk_row(oah_pkg::OP_INSERT, 31'd138, 0,
                               oah_pkg::ST_INSERTED, 50, 31'd0, 1'b0, 2, 3));
    dir_rows.push_back(op_row(oah_pkg::OP_INSERT, 31'h2AAAAAAA, 0));
    dir_rows.push_back(cfg_row(oah_pkg::CFG_PROBE_MODE,
                               oah_pkg::CFG_DATA_W'(PM_LINEAR_ALT)));
    dir_rows.push_back(chk_row(oah_pkg::OP_INSERT, 31'd10, 0,
                               oah_pkg::ST_INSERTED, 11, 31'd0, 1'b0, 1, 4));
    dir_rows.push_back(chk_row(oah_pkg::OP_READ, 31'd0, 50,
                               oah_pkg::ST_READ, 50, 31'd138, 1'b1, 2, 4));
    dir_rows.push_back(op_row(oah_pkg::OP_READ, 31'h7FFFFFFF, 42));
    dir_rows.push_back(op_row(oah_pkg::OP_INSERT, 31'h55555555, 21));
    dir_rows.push_back(chk_row(oah_pkg::OP_CLEAR, 31'h7FFFFFFF, 63,
                               oah_pkg::ST_CLEARED, 0, 31'd0, 1'b0, 0, 0));
    dir_rows.push_back(chk_row(oah_pkg::OP_READ, 31'd0, 63,
                               oah_pkg::ST_READ, 63, 31'd0, 1'b0, 0, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[n]) begin
      case (dir_rows[n].kind)
        ROW_REG:   write_reg(dir_rows[n].idx, dir_rows[n].data);
        ROW_TYPED: send_word(dir_rows[n].word, 1'b1, dir_rows[n].want);
        default:   send_word(dir_rows[n].word, 1'b0, '0);
      endcase
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      reg_data = oah_pkg::CFG_DATA_W'($urandom);
      reg_data[oah_pkg::PMODE_W-1:0] = oah_pkg::PMODE_W'(ph % 4);
      write_reg(oah_pkg::CFG_PROBE_MODE, reg_data);
      case (ph % 6)
        0, 5:    reg_data = 8'd255;
        1:       reg_data = 8'd0;
        2:       reg_data = oah_pkg::CFG_DATA_W'($urandom_range(1, 10));
        3:       reg_data = oah_pkg::MAX_PROBES_RST;
        default: reg_data = oah_pkg::CFG_DATA_W'($urandom);
      endcase
      write_reg(oah_pkg::CFG_MAX_PROBES, reg_data);
      // odd phases never clear, so the table fills and inserts give up
      for (int k = 0; k < PHASE_ITEMS; k++) send_word(pick_word(ph % 2 == 0), 1'b0, '0);
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("open_addressing_hash_insert_top verification clean");
    end else begin
      $display("open_addressing_hash_insert_top verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/oah_pkg.sv
rtl/oah_stream_if.sv
rtl/open_addressing_hash_insert_top.sv
tb/tb_open_addressing_hash_insert_top.sv
